/* sv/dtss_pkg.sv */
// Shared types, constants and widths for the daily time switch schedule block.
package dtss_pkg;

    // Sizing
    localparam int CHANNELS           = 5;
    localparam int EVENTS_PER_CHANNEL = 8;
    localparam int ENTRIES            = CHANNELS * EVENTS_PER_CHANNEL;
    localparam int ADDR_W             = $clog2(ENTRIES);
    localparam int EVT_W              = $clog2(EVENTS_PER_CHANNEL);
    localparam int CNT_W              = $clog2(EVENTS_PER_CHANNEL + 1);

    // Field widths
    localparam int CMD_W     = 2;
    localparam int CH_W      = 3;
    localparam int SLOT_W    = 3;
    localparam int HOUR_W    = 5;
    localparam int MIN_W     = 6;
    localparam int WORD_W    = 16;
    localparam int ELAPSED_W = 16;
    localparam int SECS_W    = 17;
    localparam int TOD_W     = 11;   // minutes of day, up to 31*60+63

    // Time constants
    localparam int MIN_PER_HOUR = 60;
    localparam int SEC_PER_MIN  = 60;
    localparam int DAY_MINUTES  = 1440;

    // Register reset
    localparam logic [CHANNELS-1:0] TMASK_RESET = CHANNELS'(28);

    // Stream widths
    localparam int IN_FIELDS_W  = CH_W + SLOT_W + HOUR_W + MIN_W + 2 * WORD_W
                                  + HOUR_W + MIN_W + ELAPSED_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * EVT_W + 2 * WORD_W + 2 + SECS_W + 2 * CHANNELS;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_EVAL  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // Input item as it sits in tdata, first field lowest
    typedef struct packed {
        logic [ELAPSED_W-1:0]     elapsed_seconds;
        logic [MIN_W-1:0]         now_minute;
        logic [HOUR_W-1:0]        now_hour;
        logic signed [WORD_W-1:0] data_second;
        logic signed [WORD_W-1:0] data_first;
        logic [MIN_W-1:0]         event_minute;
        logic [HOUR_W-1:0]        event_hour;
        logic [SLOT_W-1:0]        slot;
        logic [CH_W-1:0]          channel;
    } t_item_data;

    // Result item as it sits in tdata, first field lowest
    typedef struct packed {
        logic [CHANNELS-1:0]      timer_mask;
        logic [CHANNELS-1:0]      relay_mask;
        logic [SECS_W-1:0]        seconds_left;
        logic                     timer_running;
        logic                     relay_on;
        logic signed [WORD_W-1:0] level_low;
        logic signed [WORD_W-1:0] level_high;
        logic [EVT_W-1:0]         next_index;
        logic [EVT_W-1:0]         current_index;
    } t_result;

    // One stored event
    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [WORD_W-1:0] word_first;
        logic [WORD_W-1:0] word_second;
    } t_event;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_CUR_RD,
        ST_CUR_LD,
        ST_NXT_RD,
        ST_NXT_LD,
        ST_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_START,
        OP_RD_WALK,
        OP_CMP,
        OP_RD_CUR,
        OP_LD_CUR,
        OP_RD_NXT,
        OP_LD_END,
        OP_COMMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic n_zero;   // addressed channel has an empty program or is out of range
        logic hit;      // current time lies before the event just read
        logic j_last;   // walk index is at the last event
    } t_dp_sts;

endpackage

/* sv/dtss_ctrl.sv */
// Controller state machine: sequences one item through the datapath and owns the output valid.
module dtss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    input  logic             i_m_ready,
    input  dtss_pkg::t_dp_sts i_sts,
    output logic             o_s_ready,
    output logic             o_m_valid,
    output dtss_pkg::t_dp_ctl o_ctl
);
    import dtss_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_ready;

    // State register and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (i_sts.cmd == CMD_EVAL && !i_sts.n_zero) n_state = ST_WALK_RD;
                else n_state = ST_FINISH;
            end
            ST_WALK_RD:  n_state = ST_WALK_CMP;
            ST_WALK_CMP: begin
                if (i_sts.hit || i_sts.j_last) n_state = ST_CUR_RD;
                else n_state = ST_WALK_RD;
            end
            ST_CUR_RD: n_state = ST_CUR_LD;
            ST_CUR_LD: n_state = ST_NXT_RD;
            ST_NXT_RD: n_state = ST_NXT_LD;
            ST_NXT_LD: n_state = ST_FINISH;
            ST_FINISH: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath commands and handshake outputs
    always_comb begin
        o_s_ready   = 1'b0;
        o_ctl.op    = OP_NONE;
        n_out_valid = r_out_valid && !i_m_ready;
        unique case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) o_ctl.op = OP_CAPTURE;
            end
            ST_DECODE:   o_ctl.op = OP_START;
            ST_WALK_RD:  o_ctl.op = OP_RD_WALK;
            ST_WALK_CMP: o_ctl.op = OP_CMP;
            ST_CUR_RD:   o_ctl.op = OP_RD_CUR;
            ST_CUR_LD:   o_ctl.op = OP_LD_CUR;
            ST_NXT_RD:   o_ctl.op = OP_RD_NXT;
            ST_NXT_LD:   o_ctl.op = OP_LD_END;
            ST_FINISH: begin
                if (out_free) begin
                    o_ctl.op    = OP_COMMIT;
                    n_out_valid = 1'b1;
                end
            end
            default: o_ctl.op = OP_NONE;
        endcase
    end

    assign o_m_valid = r_out_valid;

endmodule

/* sv/dtss_dp.sv */
// Datapath: event memory, per-channel counts and countdowns, walk registers and result register.
module dtss_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dtss_pkg::CHANNELS-1:0]  i_cfg_wdata,
    input  dtss_pkg::t_cmd                 i_cmd,
    input  logic                           i_last,
    input  dtss_pkg::t_item_data           i_item,
    input  dtss_pkg::t_dp_ctl              i_ctl,
    output dtss_pkg::t_dp_sts              o_sts,
    output logic                           o_status,
    output dtss_pkg::t_result              o_result
);
    import dtss_pkg::*;

    // Configuration and channel state
    logic [CHANNELS-1:0] r_tmask;
    logic [CNT_W-1:0]    r_count [CHANNELS];
    logic [SECS_W-1:0]   r_cd    [CHANNELS];
    logic [CHANNELS-1:0] r_relay, r_timer;

    // Event memory
    t_event r_mem [ENTRIES];
    t_event r_rd;

    // Captured item
    t_cmd                 r_cmd;
    logic                 r_last;
    t_item_data           r_item;
    logic [TOD_W-1:0]     r_now_t;

    // Walk registers
    logic [EVT_W-1:0]  r_j, r_cur, r_nxt;
    logic [WORD_W-1:0] r_hi, r_lo;
    logic [TOD_W-1:0]  r_end;

    // Result register
    t_result r_res;
    logic    r_status;

    // Combinational helpers
    logic                ch_ok, slot_ok, is_timer, commit;
    logic [CNT_W-1:0]    n;
    logic [CNT_W-1:0]    cur_inc;
    logic [ADDR_W-1:0]   base, rd_addr, wr_addr;
    logic                rd_en;
    logic [TOD_W-1:0]    now_t_in, minutes;
    logic [SECS_W-1:0]   secs;
    logic [CHANNELS-1:0] n_relay, n_timer;
    logic [SECS_W-1:0]   n_cd [CHANNELS];
    t_result             n_res;
    logic                n_status;
    logic [CHANNELS-1:0] cd_nz, cd_ok;

    assign ch_ok   = int'(r_item.channel) < CHANNELS;
    assign slot_ok = int'(r_item.slot) < EVENTS_PER_CHANNEL;
    assign is_timer = ch_ok && r_tmask[r_item.channel];
    assign n       = ch_ok ? r_count[r_item.channel] : '0;
    assign base    = ADDR_W'(int'(r_item.channel) * EVENTS_PER_CHANNEL);
    assign wr_addr = base + ADDR_W'(r_item.slot);
    assign commit  = (i_ctl.op == OP_COMMIT);
    assign cur_inc = CNT_W'(r_cur) + CNT_W'(1);
    assign now_t_in = TOD_W'(i_item.now_hour) * TOD_W'(MIN_PER_HOUR)
                      + TOD_W'(i_item.now_minute);

    // Status toward the controller
    always_comb begin
        o_sts.cmd    = r_cmd;
        o_sts.n_zero = (n == '0);
        o_sts.hit    = (r_item.now_hour < r_rd.hour)
                       || (r_item.now_hour == r_rd.hour && r_item.now_minute < r_rd.minute);
        o_sts.j_last = (CNT_W'(r_j) + CNT_W'(1)) == n;
    end

    // Read address select
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = base + ADDR_W'(r_j);
        unique case (i_ctl.op)
            OP_RD_WALK: rd_addr = base + ADDR_W'(r_j);
            OP_RD_CUR:  rd_addr = base + ADDR_W'(r_cur);
            OP_RD_NXT:  rd_addr = base + ADDR_W'(r_nxt);
            default:    rd_en   = 1'b0;
        endcase
    end

    // Event memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (commit && r_cmd == CMD_WRITE && ch_ok && slot_ok) begin
            r_mem[wr_addr] <= '{hour: r_item.event_hour, minute: r_item.event_minute,
                                word_first: r_item.data_first,
                                word_second: r_item.data_second};
        end
        if (rd_en) r_rd <= r_mem[rd_addr];
    end

    // Item capture and walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= CMD_NONE;
        end else if (i_ctl.op == OP_CAPTURE) begin
            r_cmd <= i_cmd;
        end
        unique case (i_ctl.op)
            OP_CAPTURE: begin
                r_last  <= i_last;
                r_item  <= i_item;
                r_now_t <= now_t_in;
            end
            OP_START: r_j <= '0;
            OP_CMP: begin
                // first event later than now: the one before it is in force,
                // and a time before the first event wraps to the last one
                if (o_sts.hit) begin
                    r_cur <= (r_j == '0) ? EVT_W'(n - CNT_W'(1)) : r_j - EVT_W'(1);
                end else begin
                    r_cur <= r_j;
                end
                r_j <= r_j + EVT_W'(1);
            end
            OP_RD_CUR: r_nxt <= (cur_inc >= n) ? '0 : EVT_W'(cur_inc);
            OP_LD_CUR: begin
                r_hi <= r_rd.word_first;
                r_lo <= r_rd.word_second;
            end
            OP_LD_END: begin
                r_end <= (r_nxt == '0) ? TOD_W'(DAY_MINUTES)
                       : TOD_W'(r_rd.hour) * TOD_W'(MIN_PER_HOUR) + TOD_W'(r_rd.minute);
            end
            default: ;
        endcase
    end

    // Countdown length in minutes, saturated to a day
    always_comb begin
        minutes = (r_end > r_now_t) ? r_end - r_now_t : '0;
        if (minutes > TOD_W'(DAY_MINUTES)) minutes = TOD_W'(DAY_MINUTES);
        secs = SECS_W'(minutes) * SECS_W'(SEC_PER_MIN);
    end

    // Commit: next channel state and result
    always_comb begin
        n_relay  = r_relay;
        n_timer  = r_timer;
        n_cd     = r_cd;
        n_res    = '0;
        n_status = 1'b0;
        unique case (r_cmd)
            CMD_EVAL: begin
                if (n == '0) begin
                    n_status = 1'b1;
                end else begin
                    n_res.current_index = r_cur;
                    n_res.next_index    = r_nxt;
                    n_res.level_high    = r_hi;
                    n_res.level_low     = r_lo;
                    if (is_timer) begin
                        if (r_hi != '0) begin
                            n_relay[r_item.channel] = 1'b1;
                            n_timer[r_item.channel] = (r_nxt != r_cur);
                            n_cd[r_item.channel]    = (r_nxt != r_cur) ? secs : '0;
                        end else begin
                            n_relay[r_item.channel] = 1'b0;
                            n_timer[r_item.channel] = 1'b0;
                            n_cd[r_item.channel]    = '0;
                        end
                        n_res.relay_on      = n_relay[r_item.channel];
                        n_res.timer_running = n_timer[r_item.channel];
                        n_res.seconds_left  = n_cd[r_item.channel];
                    end
                end
            end
            CMD_TICK: begin
                // one subtractor lane per channel; a zero countdown is skipped
                for (int i = 0; i < CHANNELS; i++) begin
                    if (r_cd[i] != '0) begin
                        if (SECS_W'(r_item.elapsed_seconds) >= r_cd[i]) begin
                            n_cd[i]    = '0;
                            n_timer[i] = 1'b0;
                        end else begin
                            n_cd[i] = r_cd[i] - SECS_W'(r_item.elapsed_seconds);
                        end
                    end
                end
            end
            CMD_WRITE: ;
            CMD_NONE:  ;
        endcase
        n_res.relay_mask = n_relay;
        n_res.timer_mask = n_timer;
    end

    // Channel state, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tmask <= TMASK_RESET;
            r_relay <= '0;
            r_timer <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_count[i] <= '0;
                r_cd[i]    <= '0;
            end
        end else begin
            if (i_cfg_we) r_tmask <= i_cfg_wdata;
            if (commit) begin
                r_relay <= n_relay;
                r_timer <= n_timer;
                r_cd    <= n_cd;
                if (r_cmd == CMD_WRITE && ch_ok && slot_ok && r_last) begin
                    r_count[r_item.channel] <= CNT_W'(r_item.slot) + CNT_W'(1);
                end
            end
        end
        if (commit) begin
            r_res    <= n_res;
            r_status <= n_status;
        end
    end

    assign o_result = r_res;
    assign o_status = r_status;

    // Per-channel views for the checks below
    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            cd_nz[i] = (r_cd[i] != '0);
            cd_ok[i] = (r_cd[i] <= SECS_W'(DAY_MINUTES * SEC_PER_MIN));
        end
    end

    a_timer_needs_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_timer & ~r_relay) == '0)
        else $error("timer bit set on a channel whose relay is off");

    a_countdown_has_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cd_nz & ~r_timer) == '0)
        else $error("running countdown without its timer bit");

    a_countdown_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cd_ok == '1)
        else $error("countdown above one day");

    a_walk_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.op == OP_CMP |-> (CNT_W'(r_j) < n) && $past(i_ctl.op) == OP_RD_WALK)
        else $error("event walk beyond the channel program");

endmodule

/* sv/daily_time_switch_schedule.sv */
// Top level of the daily time switch schedule: stream ports, controller and datapath.
//
//  channel   direction  payload
//  --------  ---------  -----------------------------------------------------------
//  s_axis    in         tuser = command; tlast = last_entry; tdata = event fields
//  m_axis    out        tuser = status; tdata = result fields
//  cfg       in         i_cfg_we / i_cfg_wdata = timer_channel_mask, no read-back
//
// Write, tick and unused commands go from decode straight to the finish state.
// Evaluate walks k events, k = 1 to 8, through one read and one compare state per event,
// as the event memory has a registered read; it then reads the current and next events.
// An evaluate on an empty program goes from decode straight to its error result.
// Synchronous reset presets counts, countdowns and masks, but not the event memory.
// The next item is taken while a result waits in the output register; a stalled
// output holds the block in its finish state until the waiting result is taken.
module daily_time_switch_schedule (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [dtss_pkg::CHANNELS-1:0] i_cfg_wdata,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] channel, [5:3] slot, [10:6] event_hour, [16:11] event_minute,
    // [32:17] data_first, [48:33] data_second, [53:49] now_hour,
    // [59:54] now_minute, [75:60] elapsed_seconds, [79:76] zero
    input  logic [dtss_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // [1:0] command
    input  logic [dtss_pkg::CMD_W-1:0] s_axis_tuser,
    input  logic        s_axis_tlast,
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] current_index, [5:3] next_index, [21:6] level_high, [37:22] level_low,
    // [38] relay_on, [39] timer_running, [56:40] seconds_left, [61:57] relay_mask,
    // [66:62] timer_mask, [71:67] zero
    output logic [dtss_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] status
    output logic        m_axis_tuser
);
    import dtss_pkg::*;

    t_dp_ctl    ctl;
    t_dp_sts    sts;
    t_item_data item;
    t_result    result;
    logic       status;

    assign item = s_axis_tdata[IN_FIELDS_W-1:0];

    dtss_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_sts     (sts),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_ctl     (ctl)
    );

    dtss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (t_cmd'(s_axis_tuser)),
        .i_last      (s_axis_tlast),
        .i_item      (item),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_status    (status),
        .o_result    (result)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), result};
    assign m_axis_tuser = status;

endmodule

/* tb/daily_time_switch_schedule_tb.sv */
// Self-checking stream testbench for the daily time switch schedule block.
`timescale 1ns / 100ps

module daily_time_switch_schedule_tb;
    import dtss_pkg::*;

    localparam int ITEMS_PER_PHASE = 370;
    localparam int RANDOM_PHASES   = 5;
    localparam int SETTLE_CYCLES   = 30;     // outlasts the longest evaluate
    localparam int IDLE_LIMIT      = 3000;
    localparam int MAX_REPORTS     = 10;
    localparam int LAST_MINUTE     = DAY_MINUTES - 1;

    // Expected result item: status travels on tuser, the rest on tdata
    typedef struct packed {
        logic    status;
        t_result fields;
    } t_switch_result;

    // Schedule model and result scoreboard
    class schedule_scoreboard;
        logic [CHANNELS-1:0] timer_channels;
        logic [HOUR_W-1:0]   hour_tbl [ENTRIES];
        logic [MIN_W-1:0]    minute_tbl [ENTRIES];
        logic [WORD_W-1:0]   first_tbl [ENTRIES];
        logic [WORD_W-1:0]   second_tbl [ENTRIES];
        int                  prog_count [CHANNELS];
        int                  countdown [CHANNELS];
        logic [CHANNELS-1:0] timer_bits;
        logic [CHANNELS-1:0] relay_bits;
        t_switch_result      expected_results [$];
        int                  failures;
        int                  results_seen;

        function new();
            timer_channels = TMASK_RESET;
            foreach (hour_tbl[e]) begin
                hour_tbl[e]   = '0;
                minute_tbl[e] = '0;
                first_tbl[e]  = '0;
                second_tbl[e] = '0;
            end
            foreach (prog_count[c]) begin
                prog_count[c] = 0;
                countdown[c]  = 0;
            end
            timer_bits   = '0;
            relay_bits   = '0;
            failures     = 0;
            results_seen = 0;
        endfunction

        function void set_timer_channels(logic [CHANNELS-1:0] mask);
            timer_channels = mask;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Apply one accepted item to the model and queue its result
        function void note_command(t_cmd cmd, t_item_data d, logic last);
            t_switch_result exp_item;
            int ch, e, n, j, cur, nxt, nh, nm, base, now_t, end_t, minutes, dec;
            bit before_first;
            exp_item = '0;
            ch = int'(d.channel);
            case (cmd)
                CMD_WRITE: begin
                    if (ch < CHANNELS) begin
                        e = ch * EVENTS_PER_CHANNEL + int'(d.slot);
                        hour_tbl[e]   = d.event_hour;
                        minute_tbl[e] = d.event_minute;
                        first_tbl[e]  = d.data_first;
                        second_tbl[e] = d.data_second;
                        if (last)
                            prog_count[ch] = int'(d.slot) + 1;
                    end
                end
                CMD_EVAL: begin
                    n = (ch < CHANNELS) ? prog_count[ch] : 0;
                    if (n == 0) begin
                        exp_item.status = 1'b1;
                    end else begin
                        nh = int'(d.now_hour);
                        nm = int'(d.now_minute);
                        base = ch * EVENTS_PER_CHANNEL;
                        before_first = 1'b0;
                        cur = 0;
                        // walk to the last event that has started
                        for (j = 0; j < n; j++) begin
                            if ((nh == int'(hour_tbl[base+j]) && nm < int'(minute_tbl[base+j]))
                                    || nh < int'(hour_tbl[base+j])) begin
                                if (j == 0)
                                    before_first = 1'b1;
                                else
                                    cur = j - 1;
                                break;
                            end
                            cur = j;
                        end
                        // before the first event of the day: last event still holds
                        if (before_first)
                            cur = n - 1;
                        nxt = (cur + 1 >= n) ? 0 : cur + 1;
                        exp_item.fields.current_index = EVT_W'(cur);
                        exp_item.fields.next_index    = EVT_W'(nxt);
                        exp_item.fields.level_high    = first_tbl[base+cur];
                        exp_item.fields.level_low     = second_tbl[base+cur];
                        if (timer_channels[ch]) begin
                            minutes = 0;
                            if (first_tbl[base+cur] != '0) begin
                                relay_bits[ch] = 1'b1;
                                if (nxt != cur) begin
                                    now_t = nh * MIN_PER_HOUR + nm;
                                    end_t = (nxt == 0) ? DAY_MINUTES
                                          : int'(hour_tbl[base+nxt]) * MIN_PER_HOUR
                                            + int'(minute_tbl[base+nxt]);
                                    minutes = (end_t > now_t) ? end_t - now_t : 0;
                                    if (minutes > DAY_MINUTES)
                                        minutes = DAY_MINUTES;
                                    timer_bits[ch] = 1'b1;
                                end else begin
                                    timer_bits[ch] = 1'b0;
                                end
                            end else begin
                                relay_bits[ch] = 1'b0;
                                timer_bits[ch] = 1'b0;
                            end
                            countdown[ch] = minutes * SEC_PER_MIN;
                            exp_item.fields.relay_on      = relay_bits[ch];
                            exp_item.fields.timer_running = timer_bits[ch];
                            exp_item.fields.seconds_left  = SECS_W'(countdown[ch]);
                        end
                    end
                end
                CMD_TICK: begin
                    dec = int'(d.elapsed_seconds);
                    for (j = 0; j < CHANNELS; j++) begin
                        if (countdown[j] > 0) begin
                            if (dec >= countdown[j]) begin
                                countdown[j]  = 0;
                                timer_bits[j] = 1'b0;
                            end else begin
                                countdown[j] = countdown[j] - dec;
                            end
                        end
                    end
                end
                default: ;
            endcase
            exp_item.fields.relay_mask = relay_bits;
            exp_item.fields.timer_mask = timer_bits;
            expected_results.push_back(exp_item);
        endfunction

        function void compare_field(string name, logic [SECS_W-1:0] want,
                                    logic [SECS_W-1:0] got);
            if (want !== got) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("mismatch on result %0d, %s: expected %0h, actual %0h",
                             results_seen, name, want, got);
            end
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(logic status, t_result got);
            t_switch_result want;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result item %0d: status %0b, data %0h",
                             results_seen, status, got);
            end else begin
                want = expected_results.pop_front();
                compare_field("status", SECS_W'(want.status), SECS_W'(status));
                compare_field("current_index", SECS_W'(want.fields.current_index),
                              SECS_W'(got.current_index));
                compare_field("next_index", SECS_W'(want.fields.next_index),
                              SECS_W'(got.next_index));
                compare_field("level_high", SECS_W'(want.fields.level_high),
                              SECS_W'(got.level_high));
                compare_field("level_low", SECS_W'(want.fields.level_low),
                              SECS_W'(got.level_low));
                compare_field("relay_on", SECS_W'(want.fields.relay_on),
                              SECS_W'(got.relay_on));
                compare_field("timer_running", SECS_W'(want.fields.timer_running),
                              SECS_W'(got.timer_running));
                compare_field("seconds_left", want.fields.seconds_left, got.seconds_left);
                compare_field("relay_mask", SECS_W'(want.fields.relay_mask),
                              SECS_W'(got.relay_mask));
                compare_field("timer_mask", SECS_W'(want.fields.timer_mask),
                              SECS_W'(got.timer_mask));
            end
            results_seen++;
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CHANNELS-1:0]    i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]       s_axis_tuser;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    schedule_scoreboard sb = new();

    // Generator bookkeeping: which slots hold an event, and program lengths
    bit slot_loaded [CHANNELS][EVENTS_PER_CHANNEL];
    int slot_tod    [CHANNELS][EVENTS_PER_CHANNEL];
    int prog_len    [CHANNELS];
    int items_sent  = 0;
    int send_calm   = 0;
    int recv_calm   = 0;
    int idle_cycles = 0;

    daily_time_switch_schedule u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Wait per item, with occasional runs of back-to-back items
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 40) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return 16'hFFFF;
            4: return 16'h0001;
            default: return WORD_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_item_data random_item();
        t_item_data d;
        d.channel = ($urandom_range(0, 15) == 0) ? CH_W'($urandom_range(5, 7))
                                                 : CH_W'($urandom_range(0, CHANNELS - 1));
        d.slot            = SLOT_W'($urandom_range(0, 7));
        d.event_hour      = HOUR_W'($urandom_range(0, 23));
        d.event_minute    = MIN_W'($urandom_range(0, 59));
        d.data_first      = pick_word();
        d.data_second     = pick_word();
        d.now_hour        = HOUR_W'($urandom_range(0, 23));
        d.now_minute      = MIN_W'($urandom_range(0, 59));
        d.elapsed_seconds = ELAPSED_W'($urandom_range(0, 65535));
        return d;
    endfunction

    // Drive one item and hold it until the block takes it
    task automatic issue_item(t_cmd cmd, t_item_data d, logic last);
        int gap, ch, s, k;
        bit whole;
        ch = int'(d.channel);
        s  = int'(d.slot);
        // a program length may only cover slots that hold an event
        if (cmd == CMD_WRITE && ch < CHANNELS) begin
            slot_loaded[ch][s] = 1'b1;
            slot_tod[ch][s] = int'(d.event_hour) * MIN_PER_HOUR + int'(d.event_minute);
            if (last) begin
                whole = 1'b1;
                for (k = 0; k <= s; k++)
                    if (!slot_loaded[ch][k])
                        whole = 1'b0;
                if (whole)
                    prog_len[ch] = s + 1;
                else
                    last = 1'b0;
            end
        end
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, d};
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(cmd, d, last);
        items_sent++;
    endtask

    // Directed item; times are minutes of the day
    task automatic directed(t_cmd cmd, int ch, int slot, bit last, int ev_tod,
                            int w0, int w1, int now_tod, int elapsed);
        t_item_data d;
        d.channel         = CH_W'(ch);
        d.slot            = SLOT_W'(slot);
        d.event_hour      = HOUR_W'(ev_tod / MIN_PER_HOUR);
        d.event_minute    = MIN_W'(ev_tod % MIN_PER_HOUR);
        d.data_first      = WORD_W'(w0);
        d.data_second     = WORD_W'(w1);
        d.now_hour        = HOUR_W'(now_tod / MIN_PER_HOUR);
        d.now_minute      = MIN_W'(now_tod % MIN_PER_HOUR);
        d.elapsed_seconds = ELAPSED_W'(elapsed);
        issue_item(cmd, d, last);
    endtask

    // Write a whole program, usually sorted by start time
    task automatic load_program(int ch, int len);
        t_item_data d;
        int tods [$];
        int i;
        for (i = 0; i < len; i++)
            tods.push_back($urandom_range(0, LAST_MINUTE));
        if ($urandom_range(0, 7) != 0)
            tods.sort();
        for (i = 0; i < len; i++) begin
            d = random_item();
            d.channel      = CH_W'(ch);
            d.slot         = SLOT_W'(i);
            d.event_hour   = HOUR_W'(tods[i] / MIN_PER_HOUR);
            d.event_minute = MIN_W'(tods[i] % MIN_PER_HOUR);
            if ($urandom_range(0, 2) == 0)
                d.data_first = '0;
            issue_item(CMD_WRITE, d, i == len - 1);
        end
    endtask

    // Evaluate, often right at or next to a stored event start
    task automatic evaluate_channel();
        t_item_data d;
        int ch, tod;
        d  = random_item();
        ch = int'(d.channel);
        if (ch < CHANNELS && prog_len[ch] > 0 && $urandom_range(0, 2) == 0)
            tod = slot_tod[ch][$urandom_range(0, prog_len[ch] - 1)]
                  + int'($urandom_range(0, 2)) - 1;
        else if ($urandom_range(0, 7) == 0)
            tod = ($urandom_range(0, 1) == 0) ? 0 : LAST_MINUTE;
        else
            tod = $urandom_range(0, LAST_MINUTE);
        if (tod < 0)
            tod = 0;
        if (tod > LAST_MINUTE)
            tod = LAST_MINUTE;
        d.now_hour   = HOUR_W'(tod / MIN_PER_HOUR);
        d.now_minute = MIN_W'(tod % MIN_PER_HOUR);
        issue_item(CMD_EVAL, d, 1'($urandom_range(0, 1)));
    endtask

    task automatic tick_clock();
        t_item_data d;
        d = random_item();
        case ($urandom_range(0, 5))
            0: d.elapsed_seconds = '0;
            1: d.elapsed_seconds = '1;
            2, 3: d.elapsed_seconds = ELAPSED_W'($urandom_range(1, 120));
            4: d.elapsed_seconds = ELAPSED_W'($urandom_range(1, 5000));
            default: ;
        endcase
        issue_item(CMD_TICK, d, 1'($urandom_range(0, 1)));
    endtask

    // Stray writes, writes to missing channels, unused command
    task automatic send_noise();
        t_item_data d;
        d = random_item();
        case ($urandom_range(0, 2))
            0: issue_item(CMD_WRITE, d, 1'($urandom_range(0, 1)));
            1: begin
                d.channel = CH_W'($urandom_range(CHANNELS, 7));
                issue_item(CMD_WRITE, d, 1'($urandom_range(0, 1)));
            end
            default: issue_item(CMD_NONE, d, 1'($urandom_range(0, 1)));
        endcase
    endtask

    // Stop sending and wait until every result is back and the block is idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timer_channels(logic [CHANNELS-1:0] mask);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mask;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_timer_channels(mask);
    endtask

    // Result side: random stalls, check every accepted item
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait(recv_calm);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tuser, t_result'(m_axis_tdata[OUT_FIELDS_W-1:0]));
        end
    end

    // Watchdog: cycles without any accepted item
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("daily_time_switch_schedule_tb: errors");
        $finish;
    end

    // Stimulus
    initial begin
        int phase, target, sel, len;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_NONE;
        s_axis_tlast  <= 1'b0;
        foreach (prog_len[c]) begin
            prog_len[c] = 0;
            for (int s = 0; s < EVENTS_PER_CHANNEL; s++) begin
                slot_loaded[c][s] = 1'b0;
                slot_tod[c][s]    = 0;
            end
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under the reset channel mask (channels 2..4 are timers)
        directed(CMD_EVAL,  0, 0, 0, 0, 0, 0, 0, 0);                 // empty program
        directed(CMD_EVAL,  7, 7, 1, LAST_MINUTE, -1, -1, LAST_MINUTE, 65535);
        directed(CMD_NONE,  7, 7, 1, LAST_MINUTE, 32767, -32768, LAST_MINUTE, 65535);
        directed(CMD_WRITE, 6, 7, 1, LAST_MINUTE, -1, -1, 0, 0);     // no such channel
        directed(CMD_WRITE, 2, 0, 0, 360, 32767, -32768, 0, 0);
        directed(CMD_WRITE, 2, 1, 0, 750, 0, 1, 0, 0);
        directed(CMD_WRITE, 2, 2, 1, LAST_MINUTE, -1, 32767, 0, 0);
        directed(CMD_EVAL,  2, 0, 0, 0, 0, 0, 0, 0);                 // before first event
        directed(CMD_TICK,  0, 0, 0, 0, 0, 0, 0, 65535);
        directed(CMD_TICK,  0, 0, 0, 0, 0, 0, 0, 65535);             // runs out
        directed(CMD_EVAL,  2, 0, 0, 0, 0, 0, 360, 0);               // exactly at start
        directed(CMD_TICK,  0, 0, 0, 0, 0, 0, 0, 0);
        directed(CMD_EVAL,  2, 0, 0, 0, 0, 0, 780, 0);               // relay off
        directed(CMD_EVAL,  2, 0, 0, 0, 0, 0, LAST_MINUTE, 0);       // next is midnight
        directed(CMD_TICK,  0, 0, 0, 0, 0, 0, 0, 60);                // exact expiry
        directed(CMD_WRITE, 3, 0, 1, 0, 5, 0, 0, 0);                 // one-event program
        directed(CMD_EVAL,  3, 0, 0, 0, 0, 0, LAST_MINUTE, 0);
        directed(CMD_WRITE, 0, 0, 1, 720, -32768, 32767, 0, 0);      // limit channel
        directed(CMD_EVAL,  0, 0, 0, 0, 0, 0, 719, 0);
        directed(CMD_WRITE, 4, 0, 0, 480, 1, 0, 0, 0);
        directed(CMD_WRITE, 4, 1, 1, 1200, 0, 0, 0, 0);
        directed(CMD_EVAL,  4, 0, 0, 0, 0, 0, 480, 0);
        directed(CMD_EVAL,  1, 0, 0, 0, 0, 0, 720, 0);
        directed(CMD_TICK,  0, 0, 0, 0, 0, 0, 0, 43199);
        directed(CMD_NONE,  0, 0, 0, 0, 0, 0, 0, 0);

        // random phases, each under its own channel mask
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: write_timer_channels('1);
                1: write_timer_channels('0);
                default: write_timer_channels(CHANNELS'($urandom_range(0, 31)));
            endcase
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                sel = $urandom_range(0, 99);
                if (sel < 25) begin
                    len = ($urandom_range(0, 3) == 0) ? 1
                          : $urandom_range(1, EVENTS_PER_CHANNEL);
                    load_program($urandom_range(0, CHANNELS - 1), len);
                end else if (sel < 65) begin
                    evaluate_channel();
                end else if (sel < 85) begin
                    tick_clock();
                end else begin
                    send_noise();
                end
            end
        end

        drain();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("daily_time_switch_schedule_tb: clean");
        else
            $display("daily_time_switch_schedule_tb: errors");
        $finish;
    end

endmodule
